>>> hdl/tprs_pkg.sv
// tprs_pkg: shared constants, types and the sinc tap table of the toggle to pcm resampler
// no dependencies; used by every module in hdl/ except tprs_ram
package tprs_pkg;

   localparam int TapCount   = 64;
   localparam int Oversample = 4;
   localparam int IdxW       = $clog2(TapCount);
   localparam int SlotW      = 13;
   localparam int PhaseW     = 16;
   localparam int TapW       = 16;
   localparam int CountW     = (Oversample > 1) ? $clog2(Oversample) : 1;
   localparam int ProdW      = SlotW + TapW + 1;
   localparam int AccW       = ProdW + IdxW;
   localparam int DcW        = 24;
   localparam int GainW      = 16;
   localparam int SampleW    = 16;
   localparam int CsrW       = 16;
   localparam int CsrIdxW    = 2;
   localparam int SlotFull   = 4096;
   localparam int PoleQ16    = 65208;
   localparam int Quarter    = 4 * Oversample;
   localparam int HalfQuarter = Quarter / 2;
   localparam int FullTurn    = 2 * Quarter;
   localparam longint unsigned PiQ30 = 64'd3373259426;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CsrStep = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CsrGain = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CsrMute = CsrIdxW'(2);

   typedef struct packed {
      logic            start;
      logic [IdxW-1:0] base;
   } fir_req_type;

   typedef struct packed {
      logic                   valid;
      logic signed [AccW-1:0] acc;
   } fir_res_type;

   function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
      return (idx == IdxW'(TapCount - 1)) ? '0 : idx + 1'b1;
   endfunction

   // shift and subtract quotient, only used while the tap table is built
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      logic [64:0]     rem;
      longint unsigned quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // integer sinc design, normalized by the tap magnitude sum
   function automatic logic [TapCount*TapW-1:0] build_taps();
      longint                    v [TapCount];
      longint unsigned           total;
      longint unsigned           mag;
      longint unsigned           xr;
      longint unsigned           xfull;
      longint unsigned           x2;
      longint unsigned           term;
      longint unsigned           q;
      longint                    am;
      longint                    a;
      longint                    s;
      longint                    sum;
      longint                    tap;
      logic                      neg;
      logic [TapCount*TapW-1:0]  rom;
      total = 0;
      rom   = '0;
      for (int i = 0; i < TapCount; i++) begin
         am = 2 * longint'(i) + 1 - TapCount;
         if (am < 0) am = -am;
         if (am == 0) begin
            v[i] = longint'(1) << 30;
         end else begin
            a = am;
            while (a >= FullTurn) a = a - FullTurn;
            neg = 1'b0;
            if (a >= Quarter) begin
               a   = a - Quarter;
               neg = 1'b1;
            end
            if (a > HalfQuarter) a = Quarter - a;
            xr   = udiv($unsigned(a) * PiQ30, 64'(Quarter));
            x2   = (xr * xr) >> 30;
            term = xr;
            sum  = $signed(xr);
            for (int n = 1; n <= 6; n++) begin
               term = udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
               if (n[0] == 1'b1) sum = sum - $signed(term);
               else sum = sum + $signed(term);
            end
            s     = neg ? -sum : sum;
            xfull = udiv($unsigned(am) * PiQ30, 64'(Quarter));
            if (s >= 0) v[i] = $signed(udiv($unsigned(s) << 30, xfull));
            else v[i] = -$signed(udiv($unsigned(-s) << 30, xfull));
         end
         total = total + $unsigned((v[i] < 0) ? -v[i] : v[i]);
      end
      if (total == 0) total = 1;
      for (int i = 0; i < TapCount; i++) begin
         mag = $unsigned((v[i] < 0) ? -v[i] : v[i]);
         q   = udiv(mag * 64'd32768 + (total >> 1), total);
         tap = (v[i] < 0) ? -$signed(q) : $signed(q);
         rom[i*TapW +: TapW] = tap[TapW-1:0];
      end
      return rom;
   endfunction

   // tap c sits at bits [c*TapW +: TapW], c = 0 is the oldest slot
   localparam logic [TapCount*TapW-1:0] TapRom = build_taps();

endpackage

>>> hdl/toggle_to_pcm_sinc_resampler.sv
// toggle_to_pcm_sinc_resampler: top level, csr registers, ring ram and the three units
// depends on tprs_pkg, tprs_ram, tprs_slot, tprs_fir, tprs_dc
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata[0] toggle, [7:1] zero
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[15:0] sample, signed
//  csr      in   csr_we                 csr_index, csr_wdata
//
// an item that stays inside a sub-sample or only closes one is taken without a stall
// an item that completes a pcm sample holds req_tready low until this chain is done:
// the ring ram read port supplies TapCount-1 slots to one mac, then the dc and gain
// steps share one multiplier; a pending result only stalls the end of that chain
// after reset the ring ram is zeroed one entry a cycle, all TapCount entries, req_tready low
module toggle_to_pcm_sinc_resampler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] toggle
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [15:0] sample
   input  logic                           csr_we,
   input  logic [tprs_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [tprs_pkg::CsrW-1:0]      csr_wdata
);

   logic [tprs_pkg::PhaseW-1:0]  step_ff;
   logic [tprs_pkg::GainW-1:0]   gain_ff;
   logic                         mute_ff;

   logic                         take;
   logic                         clearing;
   logic                         wr_en;
   logic [tprs_pkg::IdxW-1:0]    wr_addr;
   logic [tprs_pkg::SlotW-1:0]   wr_data;
   logic                         rd_en;
   logic [tprs_pkg::IdxW-1:0]    rd_addr;
   logic [tprs_pkg::SlotW-1:0]   rd_data;
   tprs_pkg::fir_req_type        fir_req;
   tprs_pkg::fir_res_type        fir_res;
   logic                         fir_busy;
   logic                         dc_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tprs_pkg::PhaseW'(12303);
         gain_ff <= tprs_pkg::GainW'(4096);
         mute_ff <= 1'b0;
      end else if (csr_we) begin
         priority case (csr_index)
            tprs_pkg::CsrStep: step_ff <= csr_wdata[tprs_pkg::PhaseW-1:0];
            tprs_pkg::CsrGain: gain_ff <= csr_wdata[tprs_pkg::GainW-1:0];
            tprs_pkg::CsrMute: mute_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = ~clearing & ~fir_busy & ~dc_busy;
   assign take       = req_tvalid & req_tready;

   tprs_slot u_slot (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .toggle   (req_tdata[0]),
      .step     (step_ff),
      .clearing (clearing),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .fir_req  (fir_req)
   );

   tprs_ram #(
      .Width (tprs_pkg::SlotW),
      .Depth (tprs_pkg::TapCount)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tprs_fir u_fir (
      .clock   (clock),
      .reset   (reset),
      .fir_req (fir_req),
      .rd_data (rd_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .fir_res (fir_res),
      .busy    (fir_busy)
   );

   tprs_dc u_dc (
      .clock      (clock),
      .reset      (reset),
      .fir_res    (fir_res),
      .gain       (gain_ff),
      .mute       (mute_ff),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_sample (rsp_tdata),
      .busy       (dc_busy)
   );

`ifndef NO_ASSERTIONS
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      fir_req.start |-> (!fir_busy && !dc_busy))
      else $error("fir started while a sample is still in flight");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      fir_res.valid |-> !dc_busy)
      else $error("fir sum delivered while dc stage busy");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(dc_busy))
      else $error("result appeared without a dc stage pass");
`endif

endmodule

>>> hdl/tprs_ram.sv
// tprs_ram: generic single write port, single read port ram with registered read
// no dependencies
module tprs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tprs_slot.sv
// tprs_slot: level tracking, phase accumulator, open sub-sample slot and ring writes
// depends on tprs_pkg; drives the write port of the ring ram and starts the fir
module tprs_slot (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic                         toggle,
   input  logic [tprs_pkg::PhaseW-1:0]  step,
   output logic                         clearing,
   output logic                         wr_en,
   output logic [tprs_pkg::IdxW-1:0]    wr_addr,
   output logic [tprs_pkg::SlotW-1:0]   wr_data,
   output tprs_pkg::fir_req_type        fir_req
);

   logic                          level_ff, level_in;
   logic [tprs_pkg::PhaseW-1:0]   phase_ff, phase_in;
   logic [tprs_pkg::SlotW-1:0]    open_ff, open_in;
   logic [tprs_pkg::IdxW-1:0]     idx_ff, idx_in;
   logic [tprs_pkg::CountW-1:0]   count_ff, count_in;
   logic                          clr_ff, clr_in;
   logic [tprs_pkg::IdxW-1:0]     clr_idx_ff, clr_idx_in;

   logic [tprs_pkg::PhaseW:0]     phase_sum;
   logic                          level_new;
   logic [tprs_pkg::SlotW-1:0]    part_inc;
   logic [tprs_pkg::SlotW-1:0]    head_room;
   logic [tprs_pkg::SlotW-1:0]    done_slot;

   always_comb begin
      phase_sum = {1'b0, phase_ff} + {1'b0, step};
      level_new = level_ff ^ toggle;
      part_inc  = {1'b0, phase_sum[tprs_pkg::PhaseW-1:4]} - {1'b0, phase_ff[tprs_pkg::PhaseW-1:4]};
      head_room = tprs_pkg::SlotW'(tprs_pkg::SlotFull) - {1'b0, phase_ff[tprs_pkg::PhaseW-1:4]};
      done_slot = open_ff + (level_new ? head_room : '0);

      level_in   = level_ff;
      phase_in   = phase_ff;
      open_in    = open_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = done_slot;
      fir_req    = '{start: 1'b0, base: '0};

      if (clr_ff) begin
         // zero the ring after reset, one entry per cycle
         wr_en      = 1'b1;
         wr_addr    = clr_idx_ff;
         wr_data    = '0;
         clr_idx_in = tprs_pkg::next_idx(clr_idx_ff);
         if (clr_idx_ff == tprs_pkg::IdxW'(tprs_pkg::TapCount - 1)) clr_in = 1'b0;
      end else if (take) begin
         level_in = level_new;
         phase_in = phase_sum[tprs_pkg::PhaseW-1:0];
         if (!phase_sum[tprs_pkg::PhaseW]) begin
            open_in = open_ff + (level_new ? part_inc : '0);
         end else begin
            // sub-sample boundary: close the open slot into the ring
            wr_en   = 1'b1;
            idx_in  = tprs_pkg::next_idx(idx_ff);
            open_in = level_new ? {1'b0, phase_sum[tprs_pkg::PhaseW-1:4]} : '0;
            if (count_ff == tprs_pkg::CountW'(tprs_pkg::Oversample - 1)) begin
               count_in      = '0;
               fir_req.start = 1'b1;
               fir_req.base  = tprs_pkg::next_idx(idx_in);
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         phase_ff   <= '0;
         open_ff    <= '0;
         idx_ff     <= '0;
         count_ff   <= '0;
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         level_ff   <= level_in;
         phase_ff   <= phase_in;
         open_ff    <= open_in;
         idx_ff     <= idx_in;
         count_ff   <= count_in;
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   assign clearing = clr_ff;

endmodule

>>> hdl/tprs_fir.sv
// tprs_fir: sinc fir, reads the ring one slot per cycle through a single mac
// depends on tprs_pkg; reads the ring ram, hands the sum to tprs_dc
module tprs_fir (
   input  logic                        clock,
   input  logic                        reset,
   input  tprs_pkg::fir_req_type       fir_req,
   input  logic [tprs_pkg::SlotW-1:0]  rd_data,
   output logic                        rd_en,
   output logic [tprs_pkg::IdxW-1:0]   rd_addr,
   output tprs_pkg::fir_res_type       fir_res,
   output logic                        busy
);

   logic                                issue_ff, issue_in;
   logic [tprs_pkg::IdxW-1:0]           cnt_ff, cnt_in;
   logic [tprs_pkg::IdxW-1:0]           addr_ff, addr_in;
   logic                                s1_vld_ff, s1_last_ff;
   logic signed [tprs_pkg::TapW-1:0]    tap_ff, tap_in;
   logic                                s2_vld_ff, s2_last_ff;
   logic signed [tprs_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic signed [tprs_pkg::AccW-1:0]    acc_ff, acc_in;
   logic                                done_ff;
   logic                                last_issue;

   always_comb begin
      last_issue = (cnt_ff == tprs_pkg::IdxW'(tprs_pkg::TapCount - 2));
      issue_in   = issue_ff;
      cnt_in     = cnt_ff;
      addr_in    = addr_ff;
      if (fir_req.start) begin
         issue_in = 1'b1;
         cnt_in   = '0;
         addr_in  = fir_req.base;
      end else if (issue_ff) begin
         addr_in = tprs_pkg::next_idx(addr_ff);
         cnt_in  = cnt_ff + 1'b1;
         // the oldest slot, the next one to be overwritten, is never read
         if (last_issue) issue_in = 1'b0;
      end
      tap_in  = tprs_pkg::TapRom[cnt_ff*tprs_pkg::TapW +: tprs_pkg::TapW];
      prod_in = $signed({1'b0, rd_data}) * tap_ff;
      acc_in  = acc_ff;
      if (fir_req.start) acc_in = '0;
      else if (s2_vld_ff) acc_in = acc_ff + tprs_pkg::AccW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         issue_ff  <= issue_in;
         s1_vld_ff <= issue_ff;
         s2_vld_ff <= s1_vld_ff;
         done_ff   <= s2_vld_ff & s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      addr_ff    <= addr_in;
      tap_ff     <= tap_in;
      s1_last_ff <= issue_ff & last_issue;
      s2_last_ff <= s1_last_ff;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

   assign rd_en         = issue_ff;
   assign rd_addr       = addr_ff;
   assign fir_res.valid = done_ff;
   assign fir_res.acc   = acc_ff;
   assign busy          = issue_ff | s1_vld_ff | s2_vld_ff | done_ff;

endmodule

>>> hdl/tprs_dc.sv
// tprs_dc: dc blocker, gain, mute and the result register, one shared multiplier
// depends on tprs_pkg; takes the fir sum from tprs_fir
module tprs_dc (
   input  logic                          clock,
   input  logic                          reset,
   input  tprs_pkg::fir_res_type         fir_res,
   input  logic [tprs_pkg::GainW-1:0]    gain,
   input  logic                          mute,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [tprs_pkg::SampleW-1:0]  out_sample,
   output logic                          busy
);

   localparam int WideW = 48;
   localparam int MulW  = tprs_pkg::DcW + tprs_pkg::GainW + 1;
   localparam logic signed [WideW-1:0] DcMax  = WideW'((longint'(1) << (tprs_pkg::DcW - 1)) - 1);
   localparam logic signed [WideW-1:0] DcMin  = -DcMax - 1;
   localparam logic signed [WideW-1:0] OutMax =
      WideW'((longint'(1) << (tprs_pkg::SampleW - 1)) - 1);
   localparam logic signed [WideW-1:0] OutMin = -OutMax - 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_POLE = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_GAIN = 5'b01000,
      ST_OUT  = 5'b10000
   } dc_state_type;

   function automatic logic signed [tprs_pkg::DcW-1:0] sat_dc(input logic signed [WideW-1:0] v);
      logic signed [WideW-1:0] c;
      c = (v > DcMax) ? DcMax : ((v < DcMin) ? DcMin : v);
      return c[tprs_pkg::DcW-1:0];
   endfunction

   function automatic logic signed [tprs_pkg::SampleW-1:0] sat_out(
      input logic signed [WideW-1:0] v);
      logic signed [WideW-1:0] c;
      c = (v > OutMax) ? OutMax : ((v < OutMin) ? OutMin : v);
      return c[tprs_pkg::SampleW-1:0];
   endfunction

   dc_state_type                        state_ff, state_in;
   logic signed [tprs_pkg::DcW-1:0]     x_ff, x_in;
   logic signed [tprs_pkg::DcW-1:0]     px_ff, px_in;
   logic signed [tprs_pkg::DcW-1:0]     py_ff, py_in;
   logic signed [tprs_pkg::DcW-1:0]     y_ff, y_in;
   logic signed [MulW-1:0]              mul_ff, mul_in;
   logic signed [tprs_pkg::DcW-1:0]     mul_a;
   logic signed [tprs_pkg::GainW:0]     mul_b;
   logic                                out_valid_ff, out_valid_in;
   logic [tprs_pkg::SampleW-1:0]        out_sample_ff, out_sample_in;
   logic signed [tprs_pkg::AccW-1:0]    acc_rnd;
   logic signed [WideW-1:0]             pole_term;
   logic signed [WideW-1:0]             y_sum;
   logic signed [WideW-1:0]             scaled;

   always_comb begin
      acc_rnd   = (fir_res.acc + tprs_pkg::AccW'(16384)) >>> 15;
      pole_term = WideW'((mul_ff + MulW'(32768)) >>> 16);
      y_sum     = WideW'(x_ff) - WideW'(px_ff) + pole_term;
      scaled    = WideW'((mul_ff + MulW'(256)) >>> 9);
      mul_a     = state_ff == ST_POLE ? py_ff : y_ff;
      mul_b     = state_ff == ST_POLE ? (tprs_pkg::GainW + 1)'(tprs_pkg::PoleQ16)
                                      : $signed({1'b0, gain});
      mul_in    = mul_a * mul_b;

      state_in      = state_ff;
      x_in          = x_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      y_in          = y_ff;
      out_valid_in  = out_valid_ff & ~out_ready;
      out_sample_in = out_sample_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (fir_res.valid) begin
               x_in     = sat_dc(WideW'(acc_rnd));
               state_in = ST_POLE;
            end
         end
         ST_POLE: state_in = ST_SUM;
         ST_SUM: begin
            y_in     = sat_dc(y_sum);
            px_in    = x_ff;
            py_in    = sat_dc(y_sum);
            state_in = ST_GAIN;
         end
         ST_GAIN: state_in = ST_OUT;
         ST_OUT: begin
            // hold here until the result register is free
            if (!out_valid_ff || out_ready) begin
               out_valid_in  = 1'b1;
               out_sample_in = mute ? '0 : sat_out(scaled);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         px_ff        <= '0;
         py_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      mul_ff        <= mul_in;
      out_sample_ff <= out_sample_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;
   assign busy       = state_ff != ST_IDLE;

endmodule
